// File: src/cau_pkg.sv
`default_nettype none

package cau_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QBITS = 32;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_NEG  = 3'd5;
  localparam logic [2:0] OP_NORM = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] x_real;
    logic signed [31:0] x_imag;
    logic signed [31:0] y_real;
    logic signed [31:0] y_imag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] xr;
    logic signed [31:0] xi;
    logic signed [31:0] yr;
    logic signed [31:0] yi;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic signed [63:0] p_xx;
    logic signed [63:0] p_yy;
  } mul_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [64:0] sa;
    logic signed [64:0] sb;
    logic [63:0]        den;
    logic [31:0]        res_re;
    logic [31:0]        res_im;
    logic               sat;
  } sum_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] r;
    logic [31:0] lo;
    logic [31:0] q;
  } lane_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        dz;
    logic [63:0] den;
    lane_t       re;
    lane_t       im;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        sat;
  } div_t;

  typedef struct packed {
    logic [31:0] v;
    logic        s;
  } sat_t;

  function automatic sat_t sat33(input logic signed [32:0] a);
    sat_t o;
    o.s = (a[32] != a[31]);
    if (!o.s) begin
      o.v = a[31:0];
    end else if (a[32]) begin
      o.v = 32'h8000_0000;
    end else begin
      o.v = 32'h7FFF_FFFF;
    end
    return o;
  endfunction

  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t o;
    o.s = 1'b0;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        o.v = 32'h7FFF_FFFF;
        o.s = 1'b1;
      end else begin
        o.v = mag[31:0];
      end
    end else begin
      if (mag > 64'h8000_0000) begin
        o.v = 32'h8000_0000;
        o.s = 1'b1;
      end else begin
        o.v = 32'd0 - mag[31:0];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: src/cau_mult.sv
`default_nettype none

module cau_mult (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire cau_pkg::in_t  data_in,
  output logic               ready_up,
  input  wire logic          ready_dn,
  output logic               valid,
  output cau_pkg::mul_t      data
);

  cau_pkg::mul_t data_next;

  assign ready_up = !valid || ready_dn;

  always_comb begin
    data_next.op   = data_in.opcode;
    data_next.xr   = data_in.x_real;
    data_next.xi   = data_in.x_imag;
    data_next.yr   = data_in.y_real;
    data_next.yi   = data_in.y_imag;
    data_next.p_rr = $signed(data_in.y_real) * $signed(data_in.x_real);
    data_next.p_ii = $signed(data_in.y_imag) * $signed(data_in.x_imag);
    data_next.p_ri = $signed(data_in.y_real) * $signed(data_in.x_imag);
    data_next.p_ir = $signed(data_in.y_imag) * $signed(data_in.x_real);
    data_next.p_xx = $signed(data_in.x_real) * $signed(data_in.x_real);
    data_next.p_yy = $signed(data_in.x_imag) * $signed(data_in.x_imag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: src/cau_comb.sv
`default_nettype none

module cau_comb #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire cau_pkg::mul_t data_in,
  output logic               ready_up,
  input  wire logic          ready_dn,
  output logic               valid,
  output cau_pkg::div_t      data
);

  logic           s2_valid;
  cau_pkg::sum_t  s2;
  cau_pkg::sum_t  s2_next;
  logic           s2_ready;
  cau_pkg::div_t  data_next;

  cau_pkg::sat_t  sr;
  cau_pkg::sat_t  si;
  logic [63:0]    mag_a;
  logic [63:0]    mag_b;
  logic [95:0]    dv_a;
  logic [95:0]    dv_b;
  cau_pkg::sat_t  wa;
  cau_pkg::sat_t  wb;

  assign ready_up = !s2_valid || s2_ready;
  assign s2_ready = !valid || ready_dn;

  // first half: sums of products and the short operations
  always_comb begin
    sr = '0;
    si = '0;
    s2_next.op  = data_in.op;
    s2_next.sa  = '0;
    s2_next.sb  = '0;
    s2_next.den = 64'(data_in.p_xx) + 64'(data_in.p_yy);
    case (data_in.op)
      cau_pkg::OP_ADD: begin
        sr = cau_pkg::sat33(33'(data_in.yr) + 33'(data_in.xr));
        si = cau_pkg::sat33(33'(data_in.yi) + 33'(data_in.xi));
      end
      cau_pkg::OP_SUB: begin
        sr = cau_pkg::sat33(33'(data_in.yr) - 33'(data_in.xr));
        si = cau_pkg::sat33(33'(data_in.yi) - 33'(data_in.xi));
      end
      cau_pkg::OP_CONJ: begin
        sr.v = data_in.xr;
        si = cau_pkg::sat33(33'sd0 - 33'(data_in.xi));
      end
      cau_pkg::OP_NEG: begin
        sr = cau_pkg::sat33(33'sd0 - 33'(data_in.xr));
        si = cau_pkg::sat33(33'sd0 - 33'(data_in.xi));
      end
      cau_pkg::OP_MUL: begin
        s2_next.sa = 65'(data_in.p_rr) - 65'(data_in.p_ii);
        s2_next.sb = 65'(data_in.p_ri) + 65'(data_in.p_ir);
      end
      cau_pkg::OP_DIV: begin
        s2_next.sa = 65'(data_in.p_rr) + 65'(data_in.p_ii);
        s2_next.sb = 65'(data_in.p_ir) - 65'(data_in.p_ri);
      end
      cau_pkg::OP_NORM: begin
        s2_next.sa = 65'(data_in.p_xx) + 65'(data_in.p_yy);
      end
      default: begin
      end
    endcase
    s2_next.res_re = sr.v;
    s2_next.res_im = si.v;
    s2_next.sat    = sr.s | si.s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready_up) begin
      s2_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      s2 <= s2_next;
    end
  end

  // second half: sign and magnitude, truncation, divider setup
  always_comb begin
    mag_a = s2.sa[64] ? 64'(-s2.sa) : s2.sa[63:0];
    mag_b = s2.sb[64] ? 64'(-s2.sb) : s2.sb[63:0];
    wa = cau_pkg::sat_mag(s2.sa[64], mag_a >> FRAC_BITS);
    wb = cau_pkg::sat_mag(s2.sb[64], mag_b >> FRAC_BITS);
    dv_a = {32'd0, mag_a} << FRAC_BITS;
    dv_b = {32'd0, mag_b} << FRAC_BITS;

    data_next.op     = s2.op;
    data_next.dz     = (s2.den == 64'd0);
    data_next.den    = s2.den;
    data_next.re.neg = s2.sa[64];
    data_next.re.r   = dv_a[95:32];
    data_next.re.lo  = dv_a[31:0];
    data_next.re.ovf = (dv_a[95:32] >= s2.den);
    data_next.re.q   = '0;
    data_next.im.neg = s2.sb[64];
    data_next.im.r   = dv_b[95:32];
    data_next.im.lo  = dv_b[31:0];
    data_next.im.ovf = (dv_b[95:32] >= s2.den);
    data_next.im.q   = '0;
    data_next.res_re = s2.res_re;
    data_next.res_im = s2.res_im;
    data_next.sat    = s2.sat;
    if (s2.op == cau_pkg::OP_MUL) begin
      data_next.res_re = wa.v;
      data_next.res_im = wb.v;
      data_next.sat    = wa.s | wb.s;
    end else if (s2.op == cau_pkg::OP_NORM) begin
      data_next.res_re = wa.v;
      data_next.res_im = '0;
      data_next.sat    = wa.s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s2_ready) begin
      valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      data <= data_next;
    end
  end

  a_norm_pos: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2.op == cau_pkg::OP_NORM) |-> !s2.sa[64])
    else $error("norm sum negative");

endmodule

`default_nettype wire

// File: src/cau_div_step.sv
`default_nettype none

module cau_div_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire cau_pkg::div_t data_in,
  output logic               ready_up,
  input  wire logic          ready_dn,
  output logic               valid,
  output cau_pkg::div_t      data
);

  cau_pkg::div_t data_next;
  logic [64:0]   rr_re;
  logic [64:0]   rr_im;

  assign ready_up = !valid || ready_dn;

  // one restoring step per lane: shift in a dividend bit, subtract if it fits
  always_comb begin
    data_next = data_in;
    rr_re = {data_in.re.r, data_in.re.lo[31]};
    rr_im = {data_in.im.r, data_in.im.lo[31]};
    data_next.re.lo = {data_in.re.lo[30:0], 1'b0};
    data_next.im.lo = {data_in.im.lo[30:0], 1'b0};
    if (rr_re >= {1'b0, data_in.den}) begin
      data_next.re.r = 64'(rr_re - {1'b0, data_in.den});
      data_next.re.q = {data_in.re.q[30:0], 1'b1};
    end else begin
      data_next.re.r = rr_re[63:0];
      data_next.re.q = {data_in.re.q[30:0], 1'b0};
    end
    if (rr_im >= {1'b0, data_in.den}) begin
      data_next.im.r = 64'(rr_im - {1'b0, data_in.den});
      data_next.im.q = {data_in.im.q[30:0], 1'b1};
    end else begin
      data_next.im.r = rr_im[63:0];
      data_next.im.q = {data_in.im.q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: src/complex_arithmetic_unit.sv
// Throughput: one beat per cycle; the stages are elastic, a stage holds its beat
// only while the one after it is full and held.
// The divider has 32 restoring stages, one quotient bit each.
// Reset (synchronous, rst high) empties every stage; no other state is kept.
`default_nettype none

module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cau_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cau_pkg::out_t      out_data
);

  localparam int unsigned NSTEP = cau_pkg::QBITS;

  logic           m_valid;
  cau_pkg::mul_t  m_data;
  logic           m_ready;
  logic           s1_ready;
  logic           c_valid;
  cau_pkg::div_t  c_data;
  logic           c_ready;

  logic           d_valid [NSTEP+1];
  cau_pkg::div_t  d_data  [NSTEP+1];
  logic           d_ready [NSTEP+1];

  logic           fin_ready;
  cau_pkg::out_t  out_next;
  cau_pkg::sat_t  qr;
  cau_pkg::sat_t  qi;

  assign in_stall = !s1_ready;

  cau_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .valid_in (in_valid),
    .data_in  (in_data),
    .ready_up (s1_ready),
    .ready_dn (m_ready),
    .valid    (m_valid),
    .data     (m_data)
  );

  cau_comb #(.FRAC_BITS(FRAC_BITS)) u_comb (
    .clk      (clk),
    .rst      (rst),
    .valid_in (m_valid),
    .data_in  (m_data),
    .ready_up (m_ready),
    .ready_dn (c_ready),
    .valid    (c_valid),
    .data     (c_data)
  );

  assign d_valid[0] = c_valid;
  assign d_data[0]  = c_data;
  assign c_ready    = d_ready[0];
  assign d_ready[NSTEP] = fin_ready;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    cau_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .valid_in (d_valid[k]),
      .data_in  (d_data[k]),
      .ready_up (d_ready[k]),
      .ready_dn (d_ready[k+1]),
      .valid    (d_valid[k+1]),
      .data     (d_data[k+1])
    );
  end

  assign fin_ready = !out_valid || !out_stall;

  always_comb begin
    qr = cau_pkg::sat_mag(d_data[NSTEP].re.neg, {32'd0, d_data[NSTEP].re.q});
    qi = cau_pkg::sat_mag(d_data[NSTEP].im.neg, {32'd0, d_data[NSTEP].im.q});
    if (d_data[NSTEP].re.ovf) begin
      qr.v = d_data[NSTEP].re.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      qr.s = 1'b1;
    end
    if (d_data[NSTEP].im.ovf) begin
      qi.v = d_data[NSTEP].im.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      qi.s = 1'b1;
    end
    out_next.out_real = d_data[NSTEP].res_re;
    out_next.out_imag = d_data[NSTEP].res_im;
    out_next.status   = d_data[NSTEP].sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    if (d_data[NSTEP].op == cau_pkg::OP_DIV) begin
      if (d_data[NSTEP].dz) begin
        out_next.out_real = '0;
        out_next.out_imag = '0;
        out_next.status   = cau_pkg::ST_DIV0;
      end else begin
        out_next.out_real = qr.v;
        out_next.out_imag = qi.v;
        out_next.status   = (qr.s | qi.s) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= d_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && d_valid[NSTEP]) begin
      out_data <= out_next;
    end
  end

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == cau_pkg::ST_DIV0)
      |-> (out_data.out_real == 32'd0 && out_data.out_imag == 32'd0))
    else $error("divide by zero result not cleared");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status != 2'd3))
    else $error("undefined status code");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (d_valid[NSTEP] && fin_ready) |=> out_valid)
    else $error("beat lost at output register");

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;

  localparam int FB = 16;
  localparam int NUM_RANDOM = 650;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cau_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cau_pkg::out_t out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  cau_pkg::out_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int op_count[8];
  int stall_left = 0;
  bit rx_idle_enable = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] clamp64(input logic signed [63:0] v, inout bit sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // exact 128-bit value, saturated to the signed 32-bit range
  function automatic logic [31:0] clamp_wide(input logic signed [127:0] v, inout bit sat);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sh7FFF_FFFF;
    lo = -128'sh8000_0000;
    if (v > hi) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < lo) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic [127:0] mag;
    mag = (n < 0 ? -n : n) / d;
    return n < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cau_pkg::out_t predict_complex(input cau_pkg::in_t a);
    cau_pkg::out_t r;
    bit sat;
    logic signed [127:0] xr, xi, yr, yi, num_re, num_im, den;
    sat = 1'b0;
    r = '0;
    xr = a.x_real; xi = a.x_imag; yr = a.y_real; yi = a.y_imag;
    case (a.opcode)
      cau_pkg::OP_ADD: begin
        r.out_real = clamp64(yr + xr, sat);
        r.out_imag = clamp64(yi + xi, sat);
      end
      cau_pkg::OP_SUB: begin
        r.out_real = clamp64(yr - xr, sat);
        r.out_imag = clamp64(yi - xi, sat);
      end
      cau_pkg::OP_MUL: begin
        r.out_real = clamp_wide(trunc_div(yr * xr - yi * xi, 128'sd1 << FB), sat);
        r.out_imag = clamp_wide(trunc_div(yr * xi + yi * xr, 128'sd1 << FB), sat);
      end
      cau_pkg::OP_DIV: begin
        den = xr * xr + xi * xi;
        if (den == 0) begin
          r.status = cau_pkg::ST_DIV0;
        end else begin
          num_re = (yr * xr + yi * xi) <<< FB;
          num_im = (yi * xr - yr * xi) <<< FB;
          r.out_real = clamp_wide(trunc_div(num_re, den), sat);
          r.out_imag = clamp_wide(trunc_div(num_im, den), sat);
        end
      end
      cau_pkg::OP_CONJ: begin
        r.out_real = a.x_real;
        r.out_imag = clamp64(-xi, sat);
      end
      cau_pkg::OP_NEG: begin
        r.out_real = clamp64(-xr, sat);
        r.out_imag = clamp64(-xi, sat);
      end
      cau_pkg::OP_NORM: r.out_real = clamp_wide((xr * xr + xi * xi) >>> FB, sat);
      default: ;
    endcase
    if (r.status == cau_pkg::ST_OK && sat) r.status = cau_pkg::ST_SAT;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    cau_pkg::in_t  beat;
    bit            has_want;
    cau_pkg::out_t want;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(input logic [2:0] op, input logic [31:0] xr, input logic [31:0] xi,
                         input logic [31:0] yr, input logic [31:0] yi, input bit has_want,
                         input logic [31:0] wr, input logic [31:0] wi, input logic [1:0] ws);
    row_t row;
    row.beat = '{opcode: op, x_real: xr, x_imag: xi, y_real: yr, y_imag: yi};
    row.has_want = has_want;
    row.want = '{out_real: wr, out_imag: wi, status: ws};
    dir_rows.push_back(row);
  endtask

  // drop valid only across a gap, so back-to-back beats keep it high
  task automatic send_beat(input cau_pkg::in_t beat);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data.out_real, 32'd0);
      end else begin
        cau_pkg::out_t w;
        w = expected_q.pop_front();
        if (out_data.out_real !== w.out_real)
          report_mismatch("out_real", out_data.out_real, w.out_real);
        if (out_data.out_imag !== w.out_imag)
          report_mismatch("out_imag", out_data.out_imag, w.out_imag);
        if (out_data.status !== w.status)
          report_mismatch("status", {30'd0, out_data.status}, {30'd0, w.status});
      end
      results_seen++;
    end
  end

  // random stall bursts on the result side; long stretches are left unstalled
  always @(posedge clk) begin
    if (!rx_idle_enable || (cycles / 2000) % 3 == 2) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    cau_pkg::in_t beat;
    cau_pkg::out_t want;
    add_row(cau_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
            1, 32'h0004_0000, 32'h0006_0000, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
            1, 32'h7FFF_FFFF, 32'h8000_0000, cau_pkg::ST_SAT);
    add_row(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
            1, 32'h7FFF_FFFF, 32'h8000_0001, cau_pkg::ST_SAT);
    add_row(cau_pkg::OP_SUB, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            1, 32'h0, 32'h0, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_MUL, 32'h0001_0000, 32'h0, 32'h1234_5678, 32'hFEDC_BA98,
            1, 32'h1234_5678, 32'hFEDC_BA98, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            0, 0, 0, 0);
    add_row(cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            0, 0, 0, 0);
    add_row(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
            0, 0, 0, 0);
    add_row(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h1234_5678, 32'h8000_0000,
            1, 32'h0, 32'h0, cau_pkg::ST_DIV0);
    add_row(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'hFFFE_0000,
            1, 32'h0003_0000, 32'hFFFE_0000, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
            1, 32'h7FFF_FFFF, 32'h8000_0000, cau_pkg::ST_SAT);
    add_row(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
            0, 0, 0, 0);
    add_row(cau_pkg::OP_DIV, 32'h0003_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'h0000_0005,
            0, 0, 0, 0);
    add_row(cau_pkg::OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
            1, 32'h8000_0000, 32'h7FFF_FFFF, cau_pkg::ST_SAT);
    add_row(cau_pkg::OP_CONJ, 32'h1234_5678, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1, 32'h1234_5678, 32'h8000_0001, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_NEG, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0,
            1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, cau_pkg::ST_SAT);
    add_row(cau_pkg::OP_NEG, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
            1, 32'h8000_0001, 32'h0, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_NORM, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0,
            1, 32'h0019_0000, 32'h0, cau_pkg::ST_OK);
    add_row(cau_pkg::OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
            1, 32'h7FFF_FFFF, 32'h0, cau_pkg::ST_SAT);
    add_row(cau_pkg::OP_NORM, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0,
            1, 32'h0, 32'h0, cau_pkg::ST_OK);
    add_row(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1,
            1, 32'h0, 32'h0, cau_pkg::ST_OK);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      want = predict_complex(dir_rows[i].beat);
      if (dir_rows[i].has_want && want !== dir_rows[i].want) begin
        $display("directed row %0d: predictor gives %h, table says %h",
                 i, want, dir_rows[i].want);
        errors++;
      end
      expected_q.push_back(dir_rows[i].has_want ? dir_rows[i].want : want);
      op_count[dir_rows[i].beat.opcode]++;
      send_beat(dir_rows[i].beat);
    end

    rx_idle_enable = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      beat.opcode = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      beat.x_real = pick_component();
      beat.x_imag = pick_component();
      beat.y_real = pick_component();
      beat.y_imag = pick_component();
      // hit divide by zero now and then
      if (beat.opcode == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
        beat.x_real = 32'h0;
        beat.x_imag = 32'h0;
      end
      expected_q.push_back(predict_complex(beat));
      op_count[beat.opcode]++;
      send_beat(beat);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results: add %0d sub %0d mul %0d div %0d", results_seen,
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("conj %0d neg %0d norm %0d unused opcode %0d, random gaps and stalls",
             op_count[4], op_count[5], op_count[6], op_count[7]);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
